// ===== sv/rqri_pkg.sv =====
// rqri_pkg: shared types, sizes and codes for the ring queue block
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package rqri_pkg;

    // queue depth, a power of two so that slot arithmetic wraps in the index width
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int WORD_W = 32;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REV = 2'd2;
    localparam logic [1:0] OP_ILV = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_BAD_K     = 3'd3;
    localparam logic [2:0] ST_ODD       = 3'd4;

    localparam logic signed [WORD_W-1:0] DATA_EMPTY = -32'sd1;
    localparam logic signed [WORD_W-1:0] DATA_NONE  = 32'sd0;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [WORD_W-1:0] value;
        logic [4:0]               k;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] data;
        logic [4:0]               count;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/rqri_ram.sv =====
// rqri_ram: simple dual-port ram, one write and one registered read per cycle
// no dependencies; used for the entry store and the scratch store
`timescale 1ns / 1ps
`default_nettype none

module rqri_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ring_queue_with_reverse_and_interleave.sv =====
// ring_queue_with_reverse_and_interleave: circular fifo with reverse and interleave
// depends on rqri_pkg and rqri_ram (entry store and scratch store)
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  output  | out       | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
// one item at a time: enqueue, dequeue (registered store read), reverse of k entries
// and interleave of n entries each run to the end before the next input is taken;
// the permutes copy through the scratch store one entry a cycle each way.
// synchronous active-low reset empties the queue; the store itself is not cleared.
// a finished result waits in the output register while the next input is taken.
`timescale 1ns / 1ps
`default_nettype none

module ring_queue_with_reverse_and_interleave
    import rqri_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEQ   = 3'd1;
    localparam logic [2:0] S_PASS1 = 3'd2;
    localparam logic [2:0] S_PASS2 = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [2:0]        r_state;
    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_wr_j;
    logic              r_rd_vld;
    logic              r_rev;
    logic [2:0]        r_res_status;
    logic signed [WORD_W-1:0] r_res_data;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              accept;
    logic              issue;
    logic [CNT_W-1:0]  src_off;

    logic              main_wr_en;
    logic [IDX_W-1:0]  main_wr_addr;
    logic [WORD_W-1:0] main_wr_data;
    logic              main_rd_en;
    logic [IDX_W-1:0]  main_rd_addr;
    logic [WORD_W-1:0] main_rd_data;

    logic              scr_wr_en;
    logic              scr_rd_en;
    logic [WORD_W-1:0] scr_rd_data;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // one read issued per cycle until the permute length is reached
    assign issue = ((r_state == S_PASS1) || (r_state == S_PASS2)) && (r_j != r_len);

    // source offset of destination position j
    always_comb begin
        if (r_rev) begin
            src_off = r_len - CNT_W'(1) - r_j;
        end else if (r_j[0]) begin
            src_off = (r_len >> 1) + (r_j >> 1);
        end else begin
            src_off = r_j >> 1;
        end
    end

    always_comb begin
        main_rd_en = (accept && (i_in_item.operation == OP_DEQ) && (r_count != '0))
                     || ((r_state == S_PASS1) && issue);
        main_rd_addr = (r_state == S_IDLE) ? r_head : r_head + src_off[IDX_W-1:0];

        main_wr_en = (accept && (i_in_item.operation == OP_ENQ) && (r_count != FULL))
                     || ((r_state == S_PASS2) && r_rd_vld);
        if (r_state == S_IDLE) begin
            main_wr_addr = r_head + r_count[IDX_W-1:0];
            main_wr_data = i_in_item.value;
        end else begin
            main_wr_addr = r_head + r_wr_j;
            main_wr_data = scr_rd_data;
        end

        scr_wr_en = (r_state == S_PASS1) && r_rd_vld;
        scr_rd_en = (r_state == S_PASS2) && issue;
    end

    rqri_ram #(.DEPTH(DEPTH), .WIDTH(WORD_W)) u_main (
        .i_clk     (i_clk),
        .i_wr_en   (main_wr_en),
        .i_wr_addr (main_wr_addr),
        .i_wr_data (main_wr_data),
        .i_rd_en   (main_rd_en),
        .i_rd_addr (main_rd_addr),
        .o_rd_data (main_rd_data)
    );

    rqri_ram #(.DEPTH(DEPTH), .WIDTH(WORD_W)) u_scratch (
        .i_clk     (i_clk),
        .i_wr_en   (scr_wr_en),
        .i_wr_addr (r_wr_j),
        .i_wr_data (main_rd_data),
        .i_rd_en   (scr_rd_en),
        .i_rd_addr (r_j[IDX_W-1:0]),
        .o_rd_data (scr_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            r_wr_j   <= r_j[IDX_W-1:0];
            // in S_DONE the output register is handled below
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_status <= ST_OK;
                        r_res_data   <= DATA_NONE;
                        r_rev        <= (i_in_item.operation == OP_REV);
                        r_j          <= '0;
                        r_state      <= S_DONE;
                        case (i_in_item.operation)
                            OP_ENQ: begin
                                if (r_count == FULL) begin
                                    r_res_status <= ST_OVERFLOW;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_DEQ: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_UNDERFLOW;
                                    r_res_data   <= DATA_EMPTY;
                                end else begin
                                    r_state <= S_DEQ;
                                end
                            end
                            OP_REV: begin
                                if ((i_in_item.k == '0) || (i_in_item.k > r_count)) begin
                                    r_res_status <= ST_BAD_K;
                                end else begin
                                    r_len   <= i_in_item.k;
                                    r_state <= S_PASS1;
                                end
                            end
                            default: begin
                                if (r_count[0]) begin
                                    r_res_status <= ST_ODD;
                                end else if (r_count != '0) begin
                                    r_len   <= r_count;
                                    r_state <= S_PASS1;
                                end
                            end
                        endcase
                    end
                end
                S_DEQ: begin
                    r_res_data <= main_rd_data;
                    r_head     <= r_head + IDX_W'(1);
                    r_count    <= r_count - CNT_W'(1);
                    r_state    <= S_DONE;
                end
                S_PASS1: begin
                    // last scratch write lands this cycle
                    if (issue) begin
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        r_j     <= '0;
                        r_state <= S_PASS2;
                    end
                end
                S_PASS2: begin
                    if (issue) begin
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out.status <= r_res_status;
                        r_out.data   <= r_res_data;
                        r_out.count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above depth");

    a_permute_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS1 || r_state == S_PASS2) |=> $stable(r_count) && $stable(r_head))
        else $error("count or head moved during permute");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

    a_underflow_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_UNDERFLOW) |-> (o_out_item.data == DATA_EMPTY))
        else $error("underflow transfer without all-ones data");

endmodule

`default_nettype wire
